// ===== hw/rtl/thrb_pkg.sv =====
// ----------------------------------------------------------------------------
// thrb_pkg: shared types and constants for the text history ring
// Character codes, stream widths, controller states and the command bundle
// passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package thrb_pkg;

	localparam int THRB_RING_DEPTH = 1024;

	localparam int CHAR_W     = 7;
	localparam int OFF_W      = 10;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 32;

	localparam logic [CHAR_W-1:0] CH_BELL      = 7'd7;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 7'd8;
	localparam logic [CHAR_W-1:0] CH_CR        = 7'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 7'd32;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} thrb_state_t;

	typedef struct packed {
		logic accept;  // item taken, RAM read issued
		logic commit;  // pointers updated, result register loaded
	} thrb_cmd_t;

endpackage

// ===== hw/rtl/thrb_ram.sv =====
// ----------------------------------------------------------------------------
// thrb_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module thrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/thrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// thrb_ctrl: transaction controller for the text history ring
// Takes one item, lets the RAM read land, then commits once the result
// register is free. Owns the handshake flags on both streams.
// ----------------------------------------------------------------------------
module thrb_ctrl
	import thrb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	output thrb_cmd_t cmd
);

	thrb_state_t state_q, state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// wait until the result register is empty or draining
				if (!out_valid_q || m_tready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// ===== hw/rtl/thrb_dp.sv =====
// ----------------------------------------------------------------------------
// thrb_dp: datapath of the text history ring
// Character RAM, head/tail/cursor pointers, backspace and overwrite logic,
// and the result register.
// ----------------------------------------------------------------------------
module thrb_dp
	import thrb_pkg::*;
#(
	parameter int RING_DEPTH = THRB_RING_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  thrb_cmd_t            cmd,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  logic                 in_mode,
	input  logic [CHAR_W-1:0]    in_char,
	input  logic [OFF_W-1:0]     in_offset,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int AW   = $clog2(RING_DEPTH);
	localparam int EW   = (AW > OFF_W) ? AW : OFF_W;
	localparam logic [AW-1:0] LAST    = AW'(RING_DEPTH - 1);
	localparam logic [AW:0]   DEPTH_A = (AW+1)'(RING_DEPTH);
	localparam logic [EW:0]   DEPTH_E = (EW+1)'(RING_DEPTH);

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
		return (i == LAST) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
		return (i == '0) ? LAST : i - AW'(1);
	endfunction

	function automatic logic [AW-1:0] ring_dist(input logic [AW-1:0] from,
		input logic [AW-1:0] to);
		logic [AW:0] d;
		if (to >= from) begin
			d = {1'b0, to} - {1'b0, from};
		end else begin
			d = {1'b0, to} + DEPTH_A - {1'b0, from};
		end
		return d[AW-1:0];
	endfunction

	function automatic logic [OFF_W-1:0] to_field(input logic [AW-1:0] v);
		logic [EW-1:0] e;
		e = EW'(v);
		return e[OFF_W-1:0];
	endfunction

	logic              keep_control_q;
	logic [AW-1:0]     head_q, tail_q, cur_q;
	logic              mode_q;
	logic [CHAR_W-1:0] char_q;
	logic [OFF_W-1:0]  off_q;

	// read address, from the item being accepted
	logic [EW:0]       pos_sum;
	logic [AW-1:0]     rd_addr;
	logic [CHAR_W-1:0] rd_data;

	always_comb begin
		pos_sum = (EW+1)'(tail_q) + (EW+1)'(in_offset);
		if (pos_sum >= DEPTH_E) begin
			pos_sum = pos_sum - DEPTH_E;
		end
		rd_addr = in_mode ? pos_sum[AW-1:0] : ring_prev(head_q);
	end

	// execute
	logic [AW-1:0] fill_cur, bs_prev, head_a, cur_a, head_n, tail_nx;
	logic [AW-1:0] head_new, tail_new, cur_new;
	logic          rd_ok, erased, store, wrap;

	always_comb begin
		fill_cur = ring_dist(tail_q, head_q);
		rd_ok    = mode_q && (EW'(off_q) < EW'(fill_cur));
		bs_prev  = ring_prev(head_q);
		erased   = !mode_q && !keep_control_q && (char_q == CH_BACKSPACE)
			&& (head_q != tail_q) && (rd_data != CH_CR);
		head_a   = erased ? bs_prev : head_q;
		cur_a    = (erased && bs_prev == cur_q && bs_prev != tail_q)
			? ring_prev(bs_prev) : cur_q;
		store    = !mode_q && (keep_control_q || char_q == CH_BELL
			|| char_q == CH_CR || char_q >= CH_SPACE);
		head_n   = ring_next(head_a);
		wrap     = store && (head_n == tail_q);
		tail_nx  = ring_next(tail_q);
		head_new = store ? head_n : head_a;
		tail_new = wrap ? tail_nx : tail_q;
		cur_new  = (wrap && cur_a == tail_q) ? tail_nx : cur_a;
	end

	thrb_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(RING_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.commit && store),
		.waddr(head_a),
		.wdata(char_q),
		.re   (cmd.accept),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_control_q <= 1'b0;
		end else if (cfg_we) begin
			keep_control_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cur_q  <= '0;
		end else if (cmd.commit) begin
			head_q <= head_new;
			tail_q <= tail_new;
			cur_q  <= cur_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= in_mode;
			char_q <= in_char;
			off_q  <= in_offset;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_tdata <= {2'b00, erased, wrap, to_field(ring_dist(tail_new, cur_new)),
				to_field(ring_dist(tail_new, head_new)), rd_ok,
				rd_ok ? rd_data : '0};
		end
	end

endmodule

// ===== hw/rtl/text_history_ring_with_backspace.sv =====
// ----------------------------------------------------------------------------
// text_history_ring_with_backspace: ring of recent output characters
// Each transaction is accepted, then committed. Acceptance issues the
// synchronous character RAM read (for a read at an offset, or for the newest
// character ahead of a backspace), and the commit then updates the head, tail
// and cursor and loads the result register. The next input waits for the
// commit, which waits only while the result register holds a result not yet
// taken. With mode 0 a character is stored (backspace editing and control
// dropping unless keep_control is set; the oldest character is overwritten
// when full), with mode 1 the character at read_offset from the oldest one is
// returned. Every item yields exactly one result. No clearing pass after reset.
// ----------------------------------------------------------------------------
module text_history_ring_with_backspace
	import thrb_pkg::*;
#(
	parameter int RING_DEPTH = THRB_RING_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,    // keep_control
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,      // char_in[6:0], read_offset[16:7]
	input  logic                 s_tuser,      // mode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata       // char_out[6:0], read_valid[7],
	                                           // fill_count[17:8], cursor_offset[27:18],
	                                           // dropped_oldest[28], erased_last[29]
);

	thrb_cmd_t cmd;

	thrb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd)
	);

	thrb_dp #(
		.RING_DEPTH(RING_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_mode  (s_tuser),
		.in_char  (s_tdata[CHAR_W-1:0]),
		.in_offset(s_tdata[CHAR_W+OFF_W-1:CHAR_W]),
		.m_tdata  (m_tdata)
	);

`ifndef ASSERT_OFF
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_tvalid || m_tready))
		else $error("commit while result register is held");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && cmd.commit))
		else $error("accept and commit in the same cycle");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("committed result not presented");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second transaction taken before commit");
`endif

endmodule
